FILE: sv/direction_to_sphere_uv_defines.svh
// Assertion macros shared by the checkers of direction_to_sphere_uv.
// Depends on nothing; checkers include it by its bare file name.
`ifndef DIRECTION_TO_SPHERE_UV_DEFINES_SVH
`define DIRECTION_TO_SPHERE_UV_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSU_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSU_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/dsu_pkg.sv
// Shared types, constants and helpers for direction_to_sphere_uv.
// Depends on nothing; every design module of the block imports it, the checker does not.
package dsu_pkg;

   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_COMP_WIDTH    = 16;
   localparam int TABLE_LEN         = 24;
   localparam int VEC_W             = 33;   // normalized component, |v| <= 2^31
   localparam int ACC_W             = 36;   // CORDIC datapath with gain headroom
   localparam int SQ_W              = 64;   // sum of squares and root datapath
   localparam int ROOT_STEPS        = 32;
   localparam int SHIFT_W           = 5;

   localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
      32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
   };

   typedef struct packed {
      logic hnz;   // x or z is nonzero
      logic deg;   // all components are zero
   } flag_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] ny;
      logic signed [VEC_W-1:0] azz;
      logic signed [VEC_W-1:0] azx;
      flag_type                flags;
   } side_type;

   // Left shift that brings a magnitude of at most 2^31 into [2^30, 2^31].
   function automatic logic [SHIFT_W-1:0] norm_shift(input logic [31:0] m);
      logic [SHIFT_W-1:0] s;
      s = '0;
      for (int i = 0; i < 31; i++) begin
         if (m[i]) s = SHIFT_W'(30 - i);
      end
      if (m[31]) s = '0;
      return s;
   endfunction

endpackage

FILE: sv/direction_to_sphere_uv.sv
// Top level of direction_to_sphere_uv: direction vector in, equirectangular u/v out.
// Depends on dsu_pkg, dsu_prep, dsu_sqrt and dsu_cordic.
//
//   channel   direction   words                              handshake
//   req_      in          dir_x, dir_y, dir_z                 req_valid / req_stall
//   rsp_      out         u_coord, v_coord, degenerate        rsp_valid / rsp_stall
//
// One word enters per clock while no finished word is held. The pipeline has
// 5 front-end stages, 32 root stages, 1 + min(CORDIC_STAGES, 24) CORDIC stages
// and one output register; the pipeline depth is set by the bit-per-stage
// square root and the stage-per-rotation CORDIC.
// Reset is synchronous and clears every valid bit; data registers are not reset.
// A stalled result freezes the whole pipeline, and req_stall follows at once.
module direction_to_sphere_uv import dsu_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
   parameter int COMP_WIDTH    = DEF_COMP_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COMP_WIDTH-1:0] req_dir_x,
   input  logic [COMP_WIDTH-1:0] req_dir_y,
   input  logic [COMP_WIDTH-1:0] req_dir_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_u_coord,
   output logic [16:0]           rsp_v_coord,
   output logic                  rsp_degenerate
);

   logic            en;
   logic            prep_valid, root_valid, az_valid, pol_valid;
   logic [SQ_W-1:0] sum_sq, root;
   side_type        prep_side, root_side;
   logic [31:0]     az_ang, pol_ang;
   flag_type        az_tag, pol_tag;
   logic [31:0]     theta;
   logic [32:0]     u_round, v_round;
   logic [15:0]     u_val;
   logic [16:0]     v_val;

   logic            rsp_valid_ff;
   logic [15:0]     rsp_u_ff;
   logic [16:0]     rsp_v_ff;
   logic            rsp_deg_ff;

   // The whole pipeline advances together unless a finished word is held.
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   dsu_prep #(.COMP_WIDTH(COMP_WIDTH)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .x_in      (req_dir_x),
      .y_in      (req_dir_y),
      .z_in      (req_dir_z),
      .out_valid (prep_valid),
      .sum_out   (sum_sq),
      .side_out  (prep_side)
   );

   dsu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .n_in      (sum_sq),
      .side_in   (prep_side),
      .out_valid (root_valid),
      .root_out  (root),
      .side_out  (root_side)
   );

   // Azimuth: angle of (z, x) with its own normalization.
   dsu_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_az (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .a_in      (ACC_W'(root_side.azz)),
      .b_in      (ACC_W'(root_side.azx)),
      .tag_in    (root_side.flags),
      .out_valid (az_valid),
      .ang_out   (az_ang),
      .tag_out   (az_tag)
   );

   // Polar angle: angle of (y, radial distance in the xz plane).
   dsu_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_pol (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .a_in      (ACC_W'(root_side.ny)),
      .b_in      ($signed(ACC_W'(root[33:0]))),
      .tag_in    (root_side.flags),
      .out_valid (pol_valid),
      .ang_out   (pol_ang),
      .tag_out   (pol_tag)
   );

   // Angles in the top quarter turn read as negative and clamp to zero;
   // anything past half a turn clamps to pi.
   always_comb begin
      if (pol_ang >= 32'hC000_0000) begin
         theta = '0;
      end else if (pol_ang > 32'h8000_0000) begin
         theta = 32'h8000_0000;
      end else begin
         theta = pol_ang;
      end
   end

   assign u_round = {1'b0, az_ang} + 33'd32768;
   assign v_round = {1'b0, theta} + 33'd16384;
   assign u_val   = az_tag.hnz ? u_round[31:16] : 16'd0;
   assign v_val   = 17'd65536 - v_round[31:15];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= az_valid && pol_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (pol_tag.deg) begin
            // Zero vector: fixed coordinates at the equator.
            rsp_u_ff   <= 16'd0;
            rsp_v_ff   <= 17'd32768;
            rsp_deg_ff <= 1'b1;
         end else begin
            rsp_u_ff   <= u_val;
            rsp_v_ff   <= v_val;
            rsp_deg_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_u_coord    = rsp_u_ff;
   assign rsp_v_coord    = rsp_v_ff;
   assign rsp_degenerate = rsp_deg_ff;

endmodule

FILE: sv/dsu_prep.sv
// Front end: input register, normalization, squares and their sum.
// Depends on dsu_pkg.
module dsu_prep import dsu_pkg::*; #(
   parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [COMP_WIDTH-1:0] x_in,
   input  logic [COMP_WIDTH-1:0] y_in,
   input  logic [COMP_WIDTH-1:0] z_in,
   output logic                  out_valid,
   output logic [SQ_W-1:0]       sum_out,
   output side_type              side_out
);

   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [COMP_WIDTH-1:0]   x1_ff, y1_ff, z1_ff;
   logic signed [VEC_W-1:0] xs, ys, zs;
   logic [VEC_W-1:0]        mx, my, mz;
   logic [31:0]             mh, mall;
   logic signed [VEC_W-1:0] x2_ff, y2_ff, z2_ff;
   logic [SHIFT_W-1:0]      sh2_ff, sa2_ff;
   flag_type                f2_ff, f3_ff, f4_ff;
   logic signed [VEC_W-1:0] nx3_ff, ny3_ff, nz3_ff, azx3_ff, azz3_ff;
   logic [VEC_W-1:0]        ax3, az3;
   logic [SQ_W-1:0]         sqx4_ff, sqz4_ff;
   logic signed [VEC_W-1:0] ny4_ff, azx4_ff, azz4_ff;
   logic [SQ_W-1:0]         sum5_ff;
   side_type                side5_ff;

   assign xs = VEC_W'($signed(x1_ff));
   assign ys = VEC_W'($signed(y1_ff));
   assign zs = VEC_W'($signed(z1_ff));
   assign mx = xs[VEC_W-1] ? -xs : xs;
   assign my = ys[VEC_W-1] ? -ys : ys;
   assign mz = zs[VEC_W-1] ? -zs : zs;
   assign mh   = (mx > mz) ? mx[31:0] : mz[31:0];
   assign mall = (mh > my[31:0]) ? mh : my[31:0];

   assign ax3 = nx3_ff[VEC_W-1] ? -nx3_ff : nx3_ff;
   assign az3 = nz3_ff[VEC_W-1] ? -nz3_ff : nz3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x_in;
         y1_ff <= y_in;
         z1_ff <= z_in;

         x2_ff     <= xs;
         y2_ff     <= ys;
         z2_ff     <= zs;
         sh2_ff    <= norm_shift(mh);
         sa2_ff    <= norm_shift(mall);
         f2_ff.hnz <= (mh != '0);
         f2_ff.deg <= (mall == '0);

         // Azimuth pair uses its own scale; the polar triple uses the common one.
         azx3_ff <= x2_ff <<< sh2_ff;
         azz3_ff <= z2_ff <<< sh2_ff;
         nx3_ff  <= x2_ff <<< sa2_ff;
         ny3_ff  <= y2_ff <<< sa2_ff;
         nz3_ff  <= z2_ff <<< sa2_ff;
         f3_ff   <= f2_ff;

         sqx4_ff <= SQ_W'(ax3[31:0]) * SQ_W'(ax3[31:0]);
         sqz4_ff <= SQ_W'(az3[31:0]) * SQ_W'(az3[31:0]);
         ny4_ff  <= ny3_ff;
         azx4_ff <= azx3_ff;
         azz4_ff <= azz3_ff;
         f4_ff   <= f3_ff;

         sum5_ff        <= sqx4_ff + sqz4_ff;
         side5_ff.ny    <= ny4_ff;
         side5_ff.azz   <= azz4_ff;
         side5_ff.azx   <= azx4_ff;
         side5_ff.flags <= f4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign sum_out   = sum5_ff;
   assign side_out  = side5_ff;

endmodule

FILE: sv/dsu_sqrt.sv
// Integer square root, one result bit per pipeline stage.
// Depends on dsu_pkg.
module dsu_sqrt import dsu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [SQ_W-1:0] n_in,
   input  side_type        side_in,
   output logic            out_valid,
   output logic [SQ_W-1:0] root_out,
   output side_type        side_out
);

   logic            v_ff    [ROOT_STEPS];
   logic [SQ_W-1:0] n_ff    [ROOT_STEPS];
   logic [SQ_W-1:0] res_ff  [ROOT_STEPS];
   side_type        side_ff [ROOT_STEPS];

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * k);
      logic            v_cur;
      logic [SQ_W-1:0] n_cur, r_cur, trial;
      side_type        s_cur;

      if (k == 0) begin : g_first
         assign v_cur = in_valid;
         assign n_cur = n_in;
         assign r_cur = '0;
         assign s_cur = side_in;
      end else begin : g_next
         assign v_cur = v_ff[k-1];
         assign n_cur = n_ff[k-1];
         assign r_cur = res_ff[k-1];
         assign s_cur = side_ff[k-1];
      end

      assign trial = r_cur + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= s_cur;
            if (n_cur >= trial) begin
               n_ff[k]   <= n_cur - trial;
               res_ff[k] <= (r_cur >> 1) + BIT;
            end else begin
               n_ff[k]   <= n_cur;
               res_ff[k] <= r_cur >> 1;
            end
         end
      end
   end

   assign out_valid = v_ff[ROOT_STEPS-1];
   assign root_out  = res_ff[ROOT_STEPS-1];
   assign side_out  = side_ff[ROOT_STEPS-1];

endmodule

FILE: sv/dsu_cordic.sv
// CORDIC vectoring pipeline: quadrant fold, then one rotation per stage.
// Depends on dsu_pkg.
module dsu_cordic import dsu_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ACC_W-1:0] a_in,
   input  logic signed [ACC_W-1:0] b_in,
   input  flag_type                tag_in,
   output logic                    out_valid,
   output logic [31:0]             ang_out,
   output flag_type                tag_out
);

   localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   logic                    v_ff   [N+1];
   logic signed [ACC_W-1:0] a_ff   [N+1];
   logic signed [ACC_W-1:0] b_ff   [N+1];
   logic [31:0]             ang_ff [N+1];
   flag_type                tag_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   // Vectors in the left half-plane are turned by half a turn first.
   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= tag_in;
         if (a_in < 0) begin
            a_ff[0]   <= -a_in;
            b_ff[0]   <= -b_in;
            ang_ff[0] <= 32'h8000_0000;
         end else begin
            a_ff[0]   <= a_in;
            b_ff[0]   <= b_in;
            ang_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[i+1] <= tag_ff[i];
            if (b_ff[i] >= 0) begin
               a_ff[i+1]   <= a_ff[i] + (b_ff[i] >>> i);
               b_ff[i+1]   <= b_ff[i] - (a_ff[i] >>> i);
               ang_ff[i+1] <= ang_ff[i] + ATAN_TAB[i];
            end else begin
               a_ff[i+1]   <= a_ff[i] - (b_ff[i] >>> i);
               b_ff[i+1]   <= b_ff[i] + (a_ff[i] >>> i);
               ang_ff[i+1] <= ang_ff[i] - ATAN_TAB[i];
            end
         end
      end
   end

   assign out_valid = v_ff[N];
   assign ang_out   = ang_ff[N];
   assign tag_out   = tag_ff[N];

endmodule

FILE: sv/dsu_checker.sv
// Port-level checks for direction_to_sphere_uv, bound to the top level.
// Depends on direction_to_sphere_uv_defines.svh.
`include "direction_to_sphere_uv_defines.svh"

module dsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_u_coord,
   input logic [16:0] rsp_v_coord,
   input logic        rsp_degenerate
);

   `DSU_ASSERT_NEXT(a_held, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_v_coord), "held word changed")
   `DSU_ASSERT_NOW(a_backpressure, rsp_valid && rsp_stall, req_stall, "input taken while output held")
   `DSU_ASSERT_NOW(a_degenerate, rsp_valid && rsp_degenerate, rsp_u_coord == 16'd0 && rsp_v_coord == 17'd32768, "bad zero-vector word")
   `DSU_ASSERT_NOW(a_v_range, rsp_valid, rsp_v_coord <= 17'd65536, "v above one")

endmodule

bind direction_to_sphere_uv dsu_checker u_dsu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_u_coord    (rsp_u_coord),
   .rsp_v_coord    (rsp_v_coord),
   .rsp_degenerate (rsp_degenerate)
);

FILE: verif/tb.sv
// Self-checking testbench for direction_to_sphere_uv: drives direction words,
// predicts u/v from a local fixed-point CORDIC model and checks every result word.
// Depends on dsu_pkg and the direction_to_sphere_uv RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dsu_pkg::*;

   localparam int STAGES    = DEF_CORDIC_STAGES;
   localparam int CW        = DEF_COMP_WIDTH;
   localparam int LATENCY   = 60;
   localparam int MAX_CYCLES = 400000;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
   } dir_word_type;

   typedef struct packed {
      logic [15:0] u;
      logic [16:0] v;
      logic        deg;
   } uv_word_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [CW-1:0] req_dir_x = '0;
   logic [CW-1:0] req_dir_y = '0;
   logic [CW-1:0] req_dir_z = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [15:0]   rsp_u_coord;
   logic [16:0]   rsp_v_coord;
   logic          rsp_degenerate;

   dir_word_type pending_dirs[$];
   uv_word_type  expected_uv[$];
   int           error_count = 0;
   int           cycle_count = 0;
   // Set at the rising edge at which the input word was taken.
   bit           req_taken = 1'b0;
   // Long receiver hold-off request, served by the receiver process.
   int           hold_off_cycles = 0;

   direction_to_sphere_uv i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_u_coord(rsp_u_coord), .rsp_v_coord(rsp_v_coord),
      .rsp_degenerate(rsp_degenerate)
   );

   always #5 clock = ~clock;

   // Arctangent table entries: atan(2^-i) as a fraction of a full turn times 2^32.
   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] t [24];
      t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
            32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721,
            32'd20860, 32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325,
            32'd162, 32'd81};
      return t[i];
   endfunction

   // Scale factor that brings a magnitude into [2^30, 2^31].
   function automatic longint pow2_scale(input longint m);
      int s;
      s = 0;
      while (m != 0 && (m << s) < 64'sd1073741824 && s < 40) s++;
      return longint'(1) << s;
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits >>= 2;
      while (bits != 0) begin
         if (n >= res + bits) begin
            n -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return longint'(res);
   endfunction

   // Vectoring CORDIC: angle of (a, b) in 2^32-per-turn units.
   function automatic logic [31:0] vector_angle(input longint a, input longint b);
      logic [31:0] ang;
      longint      da, db;
      int          n;
      ang = '0;
      n = (STAGES > 24) ? 24 : STAGES;
      if (a < 0) begin
         a = -a;
         b = -b;
         ang = 32'h8000_0000;
      end
      for (int i = 0; i < n; i++) begin
         // >>> on signed longint floors toward minus infinity.
         da = b >>> i;
         db = a >>> i;
         if (b >= 0) begin
            a += da;
            b -= db;
            ang += atan_turns(i);
         end else begin
            a -= da;
            b += db;
            ang -= atan_turns(i);
         end
      end
      return ang;
   endfunction

   function automatic uv_word_type predict_uv(input dir_word_type d);
      uv_word_type r;
      longint      x, y, z, mh, mall, f, nx, nz, theta;
      logic [31:0] ang;
      logic [32:0] sum;
      x = longint'($signed(d.x));
      y = longint'($signed(d.y));
      z = longint'($signed(d.z));
      mh = (x < 0 ? -x : x) > (z < 0 ? -z : z) ? (x < 0 ? -x : x) : (z < 0 ? -z : z);
      mall = mh > (y < 0 ? -y : y) ? mh : (y < 0 ? -y : y);
      r = '0;
      if (mall == 0) begin
         r.v = 17'd32768;
         r.deg = 1'b1;
         return r;
      end
      if (mh != 0) begin
         f = pow2_scale(mh);
         ang = vector_angle(z * f, x * f);
         sum = {1'b0, ang} + 33'd32768;
         r.u = sum[31:16];
      end
      f = pow2_scale(mall);
      nx = x * f;
      nz = z * f;
      ang = vector_angle(y * f, int_sqrt(nx * nx + nz * nz));
      // Angles past three quarters of a turn are read as negative.
      if (ang >= 32'hC000_0000) theta = longint'(ang) - (longint'(1) << 32);
      else theta = longint'(ang);
      if (theta < 0) theta = 0;
      if (theta > (longint'(1) << 31)) theta = longint'(1) << 31;
      r.v = 17'(65536 - ((theta + 16384) >> 15));
      return r;
   endfunction

   function automatic logic [CW-1:0] random_component();
      case ($urandom_range(0, 7))
         0: return CW'($urandom_range(0, 4));
         1: return -CW'($urandom_range(0, 4));
         2: return {1'b1, {(CW-1){1'b0}}};
         3: return {1'b0, {(CW-1){1'b1}}};
         4: return CW'($urandom) >>> $urandom_range(0, CW-1);
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic push_dir(input int x, input int y, input int z);
      dir_word_type d;
      d.x = CW'(x);
      d.y = CW'(y);
      d.z = CW'(z);
      pending_dirs.push_back(d);
   endtask

   // Random gap: mostly zero or short, occasionally long.
   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The input handshake is judged at the rising edge, where the block takes the word.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
   end

   // Sender: the payload changes only at a falling edge, after an accepted word or while none is offered.
   int  send_gap = 0;
   bit  send_quiet = 1'b0;
   bit  gaps_enabled = 1'b1;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            expected_uv.push_back(predict_uv({req_dir_x, req_dir_y, req_dir_z}));
            send_gap = gaps_enabled ? gap_length() : 0;
         end
         if (req_taken || !req_valid) begin
            if (send_gap > 0 || send_quiet || pending_dirs.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               dir_word_type d;
               d = pending_dirs.pop_front();
               req_valid <= 1'b1;
               req_dir_x <= d.x;
               req_dir_y <= d.y;
               req_dir_z <= d.z;
            end
         end
      end
   end

   // Receiver: random stalls plus an occasional long hold-off that fills the pipeline.
   int recv_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (gaps_enabled) begin
            recv_gap = gap_length();
            rsp_stall <= (recv_gap > 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: a result word is taken at each rising edge with valid high and no stall.
   always @(posedge clock) begin
      uv_word_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_uv.size() == 0) begin
            $error("unexpected result word u=%0d v=%0d deg=%0d",
                   rsp_u_coord, rsp_v_coord, rsp_degenerate);
            error_count++;
         end else begin
            want = expected_uv.pop_front();
            if (rsp_u_coord !== want.u) begin
               $error("u_coord expected %0d actual %0d", want.u, rsp_u_coord);
               error_count++;
            end
            if (rsp_v_coord !== want.v) begin
               $error("v_coord expected %0d actual %0d", want.v, rsp_v_coord);
               error_count++;
            end
            if (rsp_degenerate !== want.deg) begin
               $error("degenerate expected %0d actual %0d", want.deg, rsp_degenerate);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > MAX_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_dirs.size() != 0 || req_valid || expected_uv.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero vector, polar axis both ways, each axis, extremes, quadrants.
      push_dir(0, 0, 0);
      push_dir(0, 1, 0);
      push_dir(0, -1, 0);
      push_dir(0, 32767, 0);
      push_dir(0, -32768, 0);
      push_dir(1, 0, 0);
      push_dir(-1, 0, 0);
      push_dir(0, 0, 1);
      push_dir(0, 0, -1);
      push_dir(32767, 0, 0);
      push_dir(-32768, 0, 0);
      push_dir(0, 0, 32767);
      push_dir(0, 0, -32768);
      push_dir(32767, 32767, 32767);
      push_dir(-32768, -32768, -32768);
      push_dir(-32768, 32767, -32768);
      push_dir(1, 1, -1);
      push_dir(-1, -1, 1);
      push_dir(1000, -2000, -3000);
      push_dir(-5, 7, 0);
      push_dir(0, 3, -32768);
      wait_drained();

      // Pipeline fill: receiver holds off while the sender keeps offering words.
      gaps_enabled = 1'b0;
      hold_off_cycles = 150;
      for (k = 0; k < 120; k++)
         push_dir(random_component(), random_component(), random_component());
      wait_drained();
      gaps_enabled = 1'b1;

      // Random words in bursts, with a sender pause that waits for every result.
      for (k = 0; k < 1000; k++) begin
         push_dir(random_component(), random_component(), random_component());
         if (k == 500) begin
            wait_drained();
         end
         if (k % 100 == 99) begin
            // Every other stretch of 100 words runs with no idling on either side.
            gaps_enabled = (k % 200 != 99);
            while (pending_dirs.size() > 20) @(posedge clock);
         end
      end
      gaps_enabled = 1'b1;
      wait_drained();
      repeat (LATENCY) @(posedge clock);

      if (error_count == 0 && expected_uv.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
